### hdl/biq_pkg.sv
// Shared constants, types and saturation helpers for the biquad cascade.
// No dependencies; imported by biq_cell and biquad_cascade_saturating_filter.
package biq_pkg;

   localparam int SECTIONS    = 4;
   localparam int COEF_WIDTH  = 24;
   localparam int DELAY_WIDTH = 40;
   localparam int SLOTS       = 5;
   localparam int COEF_FRAC   = COEF_WIDTH - 4;
   localparam int SIG_FRAC    = 16;
   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 5;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int PROD_W      = COEF_WIDTH + DELAY_WIDTH;
   // index compare width, wide enough for the last section base and the port
   localparam int CMP_W       = ($clog2(SECTIONS * SLOTS) + 1 > INDEX_W) ?
                                ($clog2(SECTIONS * SLOTS) + 1) : INDEX_W;

   // word modes on the request channel
   localparam logic MODE_FILTER = 1'b0;
   localparam logic MODE_COEF   = 1'b1;

   // coefficient slots within a section
   localparam logic [SLOT_W-1:0] SLOT_B0 = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_B1 = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_B2 = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_A1 = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] SLOT_A2 = SLOT_W'(4);

   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

   localparam logic signed [PROD_W-1:0] SAT_HI =
      {{(PROD_W-DELAY_WIDTH+1){1'b0}}, {(DELAY_WIDTH-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SAT_LO =
      {{(PROD_W-DELAY_WIDTH+1){1'b1}}, {(DELAY_WIDTH-1){1'b0}}};

   // coefficient write from the top level: value shared by every section, enable decoded per section
   typedef struct packed {
      logic                         we;
      logic [SLOT_W-1:0]            slot;
      logic signed [COEF_WIDTH-1:0] value;
   } coef_wr_type;

   // saturate a wide signed value to the delay width
   function automatic logic signed [DELAY_WIDTH-1:0] sat_delay(
      input logic signed [PROD_W-1:0] v);
      logic signed [DELAY_WIDTH-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[DELAY_WIDTH-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[DELAY_WIDTH-1:0];
      end else begin
         r = v[DELAY_WIDTH-1:0];
      end
      return r;
   endfunction

   // sign-extend a delay-width value to the wide working width
   function automatic logic signed [PROD_W-1:0] widen(
      input logic signed [DELAY_WIDTH-1:0] v);
      return PROD_W'(v);
   endfunction

endpackage

### hdl/biq_cell.sv
// One biquad section (transposed direct form II) with its own coefficients,
// delay values and one shared multiplier. Depends on biq_pkg.
module biq_cell
   import biq_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  coef_wr_type                   coef_wr,
   input  logic                          in_valid,
   input  logic signed [DELAY_WIDTH-1:0] in_x,
   output logic                          out_valid,
   output logic signed [DELAY_WIDTH-1:0] out_y,
   output logic                          busy
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MB0  = 3'd1;
   localparam logic [2:0] ST_MB1  = 3'd2;
   localparam logic [2:0] ST_MB2  = 3'd3;
   localparam logic [2:0] ST_MA1  = 3'd4;
   localparam logic [2:0] ST_MA2  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0]                   step_ff, step_in;
   logic                         vld_ff, vld_in;
   logic signed [COEF_WIDTH-1:0] coef_ff [SLOTS];
   logic signed [DELAY_WIDTH-1:0] x_ff, x_in;
   logic signed [DELAY_WIDTH-1:0] y_ff, y_in;
   logic signed [DELAY_WIDTH-1:0] p_ff, p_in;
   logic signed [DELAY_WIDTH-1:0] acc1_ff, acc1_in;
   logic signed [DELAY_WIDTH-1:0] acc2_ff, acc2_in;
   logic signed [DELAY_WIDTH-1:0] z1_ff, z1_in;
   logic signed [DELAY_WIDTH-1:0] z2_ff, z2_in;

   logic [SLOT_W-1:0]             slot_sel;
   logic signed [COEF_WIDTH-1:0]  coef_sel;
   logic signed [DELAY_WIDTH-1:0] sig_sel;
   logic signed [PROD_W-1:0]      prod;
   logic signed [PROD_W-1:0]      prod_sh;

   // operand selection for the multiplier follows the step
   always_comb begin
      case (step_ff)
         ST_MB1:  slot_sel = SLOT_B1;
         ST_MB2:  slot_sel = SLOT_B2;
         ST_MA1:  slot_sel = SLOT_A1;
         ST_MA2:  slot_sel = SLOT_A2;
         default: slot_sel = SLOT_B0;
      endcase
   end

   assign coef_sel = coef_ff[slot_sel];
   assign sig_sel  = (step_ff inside {ST_MA1, ST_MA2}) ? y_ff : x_ff;
   assign prod     = PROD_W'(coef_sel) * PROD_W'(sig_sel);
   assign prod_sh  = prod >>> COEF_FRAC;   // floor
   assign p_in     = sat_delay(prod_sh);

   always_comb begin
      step_in = step_ff;
      vld_in  = 1'b0;
      x_in    = x_ff;
      y_in    = y_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      z1_in   = z1_ff;
      z2_in   = z2_ff;
      case (step_ff)
         ST_IDLE: begin
            if (in_valid) begin
               x_in    = in_x;
               step_in = ST_MB0;
            end
         end
         ST_MB0: step_in = ST_MB1;
         ST_MB1: begin
            y_in    = sat_delay(widen(p_ff) + widen(z1_ff));
            vld_in  = 1'b1;
            step_in = ST_MB2;
         end
         ST_MB2: begin
            acc1_in = p_ff;
            step_in = ST_MA1;
         end
         ST_MA1: begin
            acc2_in = p_ff;
            step_in = ST_MA2;
         end
         ST_MA2: begin
            z1_in   = sat_delay(widen(acc1_ff) - widen(p_ff) + widen(z2_ff));
            step_in = ST_FIN;
         end
         ST_FIN: begin
            z2_in   = sat_delay(widen(acc2_ff) - widen(p_ff));
            step_in = ST_IDLE;
         end
         default: step_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         vld_ff  <= 1'b0;
         z1_ff   <= '0;
         z2_ff   <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            coef_ff[i] <= (i == 0) ? COEF_ONE : '0;
         end
      end else begin
         step_ff <= step_in;
         vld_ff  <= vld_in;
         z1_ff   <= z1_in;
         z2_ff   <= z2_in;
         if (coef_wr.we) begin
            coef_ff[coef_wr.slot] <= coef_wr.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      p_ff    <= p_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
   end

   assign out_valid = vld_ff;
   assign out_y     = y_ff;
   assign busy      = (step_ff != ST_IDLE);

endmodule

### hdl/biquad_cascade_saturating_filter.sv
// Biquad cascade: a row of SECTIONS cells, each running its section through the steps
// MB0, MB1, MB2, MA1, MA2 and FIN on one multiplier and passing y on once it is formed in MB1.
// A result passes every cell in turn and then the output register before rsp_valid is raised.
// A sample word is taken only with no sample in flight, no held result and all cells idle, so
// the last cell finishing its delay update sets the pace; a coefficient word holds no cell.
// Synchronous reset: each section becomes a pass-through, delay values cleared.
module biquad_cascade_saturating_filter
   import biq_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   input  logic [INDEX_W-1:0]           req_coef_index,
   input  logic signed [COEF_WIDTH-1:0] req_coef_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   output logic                         rsp_clipped
);

   localparam logic signed [DELAY_WIDTH-1:0] OUT_HI =
      DELAY_WIDTH'(64'sd32767 <<< SIG_FRAC);
   localparam logic signed [DELAY_WIDTH-1:0] OUT_LO =
      DELAY_WIDTH'(-64'sd32768 <<< SIG_FRAC);

   logic                          link_valid [SECTIONS+1];
   logic signed [DELAY_WIDTH-1:0] link_y     [SECTIONS+1];
   logic [SECTIONS-1:0]           cell_busy;
   coef_wr_type                   coef_wr    [SECTIONS];

   logic                          accept, accept_smp, accept_coef;
   logic signed [SAMPLE_W+SIG_FRAC-1:0] x_full;
   logic [CMP_W-1:0]              idx_ext;

   logic                          flight_ff, flight_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                          rsp_clip_ff, rsp_clip_in;
   logic                          hold_valid_ff, hold_valid_in;
   logic signed [SAMPLE_W-1:0]    hold_sample_ff, hold_sample_in;
   logic                          hold_clip_ff, hold_clip_in;

   logic signed [DELAY_WIDTH-1:0] y_last, y_shift;
   logic signed [SAMPLE_W-1:0]    conv_sample;
   logic                          conv_clip;
   logic                          rsp_taken;

   assign req_ready   = !flight_ff && !hold_valid_ff && (cell_busy == '0);
   assign accept      = req_valid && req_ready;
   assign accept_smp  = accept && (req_mode == MODE_FILTER);
   assign accept_coef = accept && (req_mode == MODE_COEF);

   assign x_full        = {req_sample_in, SIG_FRAC'(0)};
   assign link_valid[0] = accept_smp;
   assign link_y[0]     = DELAY_WIDTH'(x_full);
   assign idx_ext       = CMP_W'(req_coef_index);

   for (genvar s = 0; s < SECTIONS; s++) begin : g_cell
      localparam logic [CMP_W-1:0] BASE = CMP_W'(s * SLOTS);
      logic [CMP_W-1:0] rel;

      assign rel              = idx_ext - BASE;
      assign coef_wr[s].we    = accept_coef && (idx_ext >= BASE) &&
                                (idx_ext < BASE + CMP_W'(SLOTS));
      assign coef_wr[s].slot  = rel[SLOT_W-1:0];
      assign coef_wr[s].value = req_coef_value;

      biq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef_wr   (coef_wr[s]),
         .in_valid  (link_valid[s]),
         .in_x      (link_y[s]),
         .out_valid (link_valid[s+1]),
         .out_y     (link_y[s+1]),
         .busy      (cell_busy[s])
      );
   end

   // truncate toward zero and saturate to the sample width
   assign y_last  = link_y[SECTIONS];
   assign y_shift = y_last >>> SIG_FRAC;
   always_comb begin
      if (y_last > OUT_HI) begin
         conv_sample = SAMPLE_W'(32767);
         conv_clip   = 1'b1;
      end else if (y_last < OUT_LO) begin
         conv_sample = -SAMPLE_W'(32768);
         conv_clip   = 1'b1;
      end else begin
         conv_sample = y_shift[SAMPLE_W-1:0] +
                       SAMPLE_W'(y_last[DELAY_WIDTH-1] && (y_last[SIG_FRAC-1:0] != '0));
         conv_clip   = 1'b0;
      end
   end

   assign rsp_taken = rsp_valid_ff && rsp_ready;

   always_comb begin
      flight_in      = flight_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_sample_in  = rsp_sample_ff;
      rsp_clip_in    = rsp_clip_ff;
      hold_valid_in  = hold_valid_ff;
      hold_sample_in = hold_sample_ff;
      hold_clip_in   = hold_clip_ff;
      if (accept_smp) begin
         flight_in = 1'b1;
      end
      if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
      // held word moves up when the output register frees
      if (hold_valid_ff && rsp_taken) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = hold_sample_ff;
         rsp_clip_in   = hold_clip_ff;
         hold_valid_in = 1'b0;
      end
      if (link_valid[SECTIONS]) begin
         flight_in = 1'b0;
         if (!rsp_valid_ff || rsp_taken) begin
            rsp_valid_in  = 1'b1;
            rsp_sample_in = conv_sample;
            rsp_clip_in   = conv_clip;
         end else begin
            hold_valid_in  = 1'b1;
            hold_sample_in = conv_sample;
            hold_clip_in   = conv_clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         flight_ff     <= flight_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff  <= rsp_sample_in;
      rsp_clip_ff    <= rsp_clip_in;
      hold_sample_ff <= hold_sample_in;
      hold_clip_ff   <= hold_clip_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

   // a result leaves the chain only for a sample word in flight
   a_result_in_flight : assert property (@(posedge clock) disable iff (reset)
      link_valid[SECTIONS] |-> flight_ff)
      else $error("cascade result without a sample in flight");

   // a held word always sits behind a full output register
   a_hold_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("held word with empty output register");

   // a sample word taken marks the chain busy on the next cycle
   a_accept_flight : assert property (@(posedge clock) disable iff (reset)
      accept_smp |=> (flight_ff && !req_ready))
      else $error("sample word taken but chain not busy");

   // a coefficient write is taken only while every section is idle
   a_one_section : assert property (@(posedge clock) disable iff (reset)
      accept_coef |-> $onehot0(cell_busy) && (cell_busy == '0))
      else $error("coefficient write while a section is busy");

endmodule

### tb/tb_top.sv
// Self-checking bench for biquad_cascade_saturating_filter: a directed table (pinned rows against
// fixed values), then random coefficient sets, raw writes and sample bursts against a fixed-point predictor.
// Depends on biq_pkg and the filter RTL only.
module tb_top
   import biq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF     = 5;
   localparam int RANDOM_WORDS = 520;
   localparam int MAX_GAP      = 12;
   localparam int UNITY        = 1 << COEF_FRAC;

   localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam int INDEX_LIMIT = SECTIONS * SLOTS;
   localparam int INDEX_TOP   = (1 << INDEX_W) - 1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       clipped;
   } audio_out_type;

   typedef struct packed {
      logic                         mode;
      logic signed [SAMPLE_W-1:0]   smp;
      logic [INDEX_W-1:0]           idx;
      logic signed [COEF_WIDTH-1:0] val;
      bit                           pinned;
      logic signed [SAMPLE_W-1:0]   out;
      logic                         clip;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_mode = MODE_FILTER;
   logic signed [SAMPLE_W-1:0]   req_sample_in = '0;
   logic [INDEX_W-1:0]           req_coef_index = '0;
   logic signed [COEF_WIDTH-1:0] req_coef_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_sample_out;
   logic                         rsp_clipped;

   logic signed [COEF_WIDTH-1:0]  coef_bank [SECTIONS*SLOTS];
   logic signed [DELAY_WIDTH-1:0] delay_bank [SECTIONS*2];
   audio_out_type                 pending_out [$];
   int                            errors = 0;
   int                            live_words = 0;
   int                            stall_left = 0;
   bit                            calm = 1'b0;

   // pinned rows are read straight off the arithmetic; the rest go through the predictor
   stim_row_type plan [26] = '{
      '{MODE_FILTER, 0,      0, 0, 1, 0,      0},
      '{MODE_FILTER, 32767,  0, 0, 1, 32767,  0},
      '{MODE_FILTER, -32768, 0, 0, 1, -32768, 0},
      '{MODE_FILTER, -1,     0, 0, 1, -1,     0},
      '{MODE_FILTER, 1,      0, 0, 1, 1,      0},
      '{MODE_COEF,   21845,  INDEX_W'(INDEX_LIMIT), COEF_MAX, 0, 0, 0},
      '{MODE_COEF,   -21846, INDEX_W'(INDEX_TOP),   COEF_MIN, 0, 0, 0},
      '{MODE_FILTER, 12345,  0, 0, 1, 12345,  0},
      '{MODE_COEF,   0,      INDEX_W'(SLOT_B0), COEF_MAX, 0, 0, 0},
      '{MODE_FILTER, 1,      0, 0, 1, 7,      0},
      '{MODE_FILTER, -1,     0, 0, 1, -8,     0},
      '{MODE_FILTER, 32767,  0, 0, 1, 32767,  1},
      '{MODE_FILTER, -32768, 0, 0, 1, -32768, 1},
      // b0 one LSB above unity: full scale lands just past 32767
      '{MODE_COEF,   0,      INDEX_W'(SLOT_B0), COEF_WIDTH'(COEF_ONE + 1), 0, 0, 0},
      '{MODE_FILTER, 32767,  0, 0, 1, 32767,  1},
      '{MODE_FILTER, -32767, 0, 0, 1, -32767, 0},
      '{MODE_FILTER, -32768, 0, 0, 1, -32768, 1},
      '{MODE_COEF,   0,      INDEX_W'(SLOT_A1), COEF_MIN, 0, 0, 0},
      '{MODE_FILTER, 32767,  0, 0, 0, 0, 0},
      '{MODE_FILTER, -32768, 0, 0, 0, 0, 0},
      '{MODE_COEF,   0,      INDEX_W'(3*SLOTS + SLOT_A2), COEF_MAX, 0, 0, 0},
      '{MODE_COEF,   0,      INDEX_W'(SLOT_A2), COEF_MIN, 0, 0, 0},
      '{MODE_FILTER, 32767,  0, 0, 0, 0, 0},
      '{MODE_FILTER, 0,      0, 0, 0, 0, 0},
      '{MODE_COEF,   0,      INDEX_W'(2*SLOTS + SLOT_B0), 0, 0, 0, 0},
      '{MODE_FILTER, -20000, 0, 0, 0, 0, 0}
   };

   biquad_cascade_saturating_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped)
   );

   always #CLK_HALF clock = ~clock;

   function automatic longint clamp_delay(input longint v);
      longint hi;
      hi = (longint'(1) << (DELAY_WIDTH - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // exact product, floor back to signal scale, saturate
   function automatic longint scaled_product(input logic signed [COEF_WIDTH-1:0] c,
                                             input longint x);
      return clamp_delay((longint'(c) * x) >>> COEF_FRAC);
   endfunction

   function automatic audio_out_type cascade_sample(input logic signed [SAMPLE_W-1:0] smp);
      longint        x, y, n1, n2, hi_lim, lo_lim;
      int            b;
      audio_out_type w;
      x = clamp_delay(longint'(smp) * (longint'(1) << SIG_FRAC));
      for (int s = 0; s < SECTIONS; s++) begin
         b  = s * SLOTS;
         y  = clamp_delay(scaled_product(coef_bank[b + SLOT_B0], x)
                          + longint'(delay_bank[2*s]));
         n1 = clamp_delay(scaled_product(coef_bank[b + SLOT_B1], x)
                          - scaled_product(coef_bank[b + SLOT_A1], y)
                          + longint'(delay_bank[2*s + 1]));
         n2 = clamp_delay(scaled_product(coef_bank[b + SLOT_B2], x)
                          - scaled_product(coef_bank[b + SLOT_A2], y));
         delay_bank[2*s]     = n1[DELAY_WIDTH-1:0];
         delay_bank[2*s + 1] = n2[DELAY_WIDTH-1:0];
         x = y;
      end
      hi_lim = longint'(32767) << SIG_FRAC;
      lo_lim = longint'(-32768) << SIG_FRAC;
      w.clipped = 1'b1;
      if (x > hi_lim) begin
         w.sample_out = 16'sh7FFF;
      end else if (x < lo_lim) begin
         w.sample_out = 16'sh8000;
      end else begin
         // integer division truncates toward zero
         w.sample_out = SAMPLE_W'(x / (longint'(1) << SIG_FRAC));
         w.clipped    = 1'b0;
      end
      return w;
   endfunction

   task automatic send_word(input logic mode, input logic [SAMPLE_W-1:0] smp,
                            input logic [INDEX_W-1:0] idx,
                            input logic [COEF_WIDTH-1:0] val, input bit pinned,
                            input logic [SAMPLE_W-1:0] p_out, input logic p_clip);
      int            gap;
      audio_out_type w;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_sample_in  <= smp;
      req_coef_index <= idx;
      req_coef_value <= val;
      do @(posedge clock); while (!req_ready);
      live_words++;
      if (mode == MODE_COEF) begin
         if (idx < INDEX_LIMIT) begin
            coef_bank[idx] = val;
         end
      end else begin
         w = cascade_sample(smp);
         if (pinned) begin
            w.sample_out = p_out;
            w.clipped    = p_clip;
         end
         pending_out.push_back(w);
      end
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
      send_word(MODE_FILTER, smp, INDEX_W'($urandom), COEF_WIDTH'($urandom), 0, '0, 1'b0);
   endtask

   task automatic send_coef(input logic [INDEX_W-1:0] idx, input logic [COEF_WIDTH-1:0] val);
      send_word(MODE_COEF, SAMPLE_W'($urandom), idx, val, 0, '0, 1'b0);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return SAMPLE_W'($urandom);
         1: return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
         2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return SAMPLE_W'(int'($urandom_range(0, 16000)) - 8000);
      endcase
   endfunction

   // stable sections: a2 within +-0.9, a1 inside the stability triangle
   task automatic load_stable_set();
      int a1, a2, lim;
      for (int s = 0; s < SECTIONS; s++) begin
         a2  = int'($urandom_range(0, (UNITY / 10) * 18)) - (UNITY / 10) * 9;
         lim = ((UNITY + a2) / 100) * 95;
         a1  = int'($urandom_range(0, 2 * lim)) - lim;
         send_coef(INDEX_W'(s*SLOTS + SLOT_B0),
                   COEF_WIDTH'(int'($urandom_range(0, 3*UNITY)) - 3*UNITY/2));
         send_coef(INDEX_W'(s*SLOTS + SLOT_B1),
                   COEF_WIDTH'(int'($urandom_range(0, 3*UNITY)) - 3*UNITY/2));
         send_coef(INDEX_W'(s*SLOTS + SLOT_B2),
                   COEF_WIDTH'(int'($urandom_range(0, 3*UNITY)) - 3*UNITY/2));
         send_coef(INDEX_W'(s*SLOTS + SLOT_A1), COEF_WIDTH'(a1));
         send_coef(INDEX_W'(s*SLOTS + SLOT_A2), COEF_WIDTH'(a2));
      end
   endtask

   // result side: check each word, then refuse the next one for a random spell
   always @(posedge clock) begin
      audio_out_type want;
      int            n;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (pending_out.size() == 0) begin
            $display("%0t: unexpected word, sample_out %0d clipped %0b",
                     $time, rsp_sample_out, rsp_clipped);
            errors++;
         end else begin
            want = pending_out.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $display("%0t: sample_out expected %0d got %0d",
                        $time, want.sample_out, rsp_sample_out);
               errors++;
            end
            if (rsp_clipped !== want.clipped) begin
               $display("%0t: clipped expected %0b got %0b",
                        $time, want.clipped, rsp_clipped);
               errors++;
            end
         end
         n = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (n == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            stall_left <= n;
         end
      end else if (!rsp_ready && rsp_valid) begin
         if (stall_left <= 1) begin
            rsp_ready <= 1'b1;
         end else begin
            stall_left <= stall_left - 1;
         end
      end
   end

   initial begin
      for (int i = 0; i < SECTIONS*SLOTS; i++)
         coef_bank[i] = (i % SLOTS == SLOT_B0) ? COEF_ONE : '0;
      for (int i = 0; i < SECTIONS*2; i++)
         delay_bank[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_word(plan[i].mode, plan[i].smp, plan[i].idx, plan[i].val,
                   plan[i].pinned, plan[i].out, plan[i].clip);

      live_words = 0;
      while (live_words < RANDOM_WORDS) begin
         calm = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: begin
               load_stable_set();
               repeat ($urandom_range(8, 30)) send_sample(pick_sample());
            end
            5, 6: begin
               // noise: raw writes anywhere, out-of-range indexes included
               repeat ($urandom_range(1, 4))
                  send_coef(INDEX_W'($urandom_range(0, INDEX_TOP)), COEF_WIDTH'($urandom));
               repeat ($urandom_range(2, 10)) send_sample(pick_sample());
            end
            default: begin
               repeat ($urandom_range(5, 20)) send_sample(pick_sample());
            end
         endcase
      end
      req_valid <= 1'b0;

      while (pending_out.size() != 0) @(posedge clock);
      repeat (3*SECTIONS + 8) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
hdl/biq_pkg.sv
hdl/biq_cell.sv
hdl/biquad_cascade_saturating_filter.sv
tb/tb_top.sv
